// ===== design/adcd_pkg.sv =====
`timescale 1ns / 1ps

package adcd_pkg;

    // Art-Net ID, "Art-Net" followed by a zero byte
    localparam logic [7:0] ART_ID [8] = '{
        8'h41, 8'h72, 8'h74, 8'h2D, 8'h4E, 8'h65, 8'h74, 8'h00
    };

    // OpDmx, little-endian on the wire
    localparam logic [7:0] OPDMX_LO = 8'h00;
    localparam logic [7:0] OPDMX_HI = 8'h50;

    localparam logic [15:0] POS_ID_END   = 16'd8;
    localparam logic [15:0] POS_OP_LO    = 16'd8;
    localparam logic [15:0] POS_OP_HI    = 16'd9;
    localparam logic [15:0] POS_UNIV_LO  = 16'd14;
    localparam logic [15:0] POS_UNIV_HI  = 16'd15;
    localparam logic [15:0] POS_LEN_HI   = 16'd16;
    localparam logic [15:0] POS_LEN_LO   = 16'd17;
    localparam logic [15:0] HDR_LEN      = 16'd18;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [9:0] channel;
        logic [7:0] level;
    } res_t;

endpackage

// ===== design/adcd_fifo.sv =====
`timescale 1ns / 1ps

module adcd_fifo
    import adcd_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic [WIDTH-1:0]               wdata,
    output logic                           full,
    input  logic                           pop,
    output logic [WIDTH-1:0]               rdata,
    output logic                           empty,
    output logic [$clog2(DEPTH+1)-1:0]     count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = store_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not rise on push");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not fall on pop");

endmodule

// ===== design/adcd_front.sv =====
`timescale 1ns / 1ps

module adcd_front
    import adcd_pkg::*;
#(
    parameter int CHANNELS = 512,
    parameter int IW       = 9
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_accept,
    input  logic [7:0]    data_byte,
    input  logic          byte_last,
    input  logic [15:0]   datagram_length,
    input  logic [14:0]   listen_universe,
    output logic          item_push,
    output logic [IW-1:0] item_idx,
    output logic [7:0]    item_level
);

    logic [15:0] pos_reg, pos_next;
    logic        hv_reg, hv_next;
    logic [15:0] univ_reg, univ_next;
    logic [15:0] plen_reg, plen_next;
    logic [15:0] plen_asm;
    logic [16:0] need_len;
    logic [15:0] idx;

    assign idx      = pos_reg - HDR_LEN;
    assign plen_asm = {plen_reg[15:8], data_byte};
    assign need_len = {1'b0, HDR_LEN} + {1'b0, plen_asm};

    always_comb
    begin
        pos_next  = pos_reg;
        hv_next   = hv_reg;
        univ_next = univ_reg;
        plen_next = plen_reg;
        item_push = 1'b0;
        if (in_accept)
        begin
            if (pos_reg < POS_ID_END)
            begin
                if (data_byte != ART_ID[pos_reg[2:0]])
                begin
                    hv_next = 1'b0;
                end
            end
            else if (pos_reg == POS_OP_LO)
            begin
                if (data_byte != OPDMX_LO)
                begin
                    hv_next = 1'b0;
                end
            end
            else if (pos_reg == POS_OP_HI)
            begin
                if (data_byte != OPDMX_HI)
                begin
                    hv_next = 1'b0;
                end
            end
            else if (pos_reg == POS_UNIV_LO)
            begin
                univ_next = {8'h00, data_byte};
            end
            else if (pos_reg == POS_UNIV_HI)
            begin
                univ_next = {data_byte, univ_reg[7:0]};
            end
            else if (pos_reg == POS_LEN_HI)
            begin
                plen_next = {data_byte, 8'h00};
            end
            else if (pos_reg == POS_LEN_LO)
            begin
                plen_next = plen_asm;
                if (datagram_length < HDR_LEN || plen_asm == '0 ||
                    {1'b0, datagram_length} < need_len ||
                    univ_reg != {1'b0, listen_universe})
                begin
                    hv_next = 1'b0;
                end
            end
            else if (pos_reg >= HDR_LEN && hv_reg)
            begin
                item_push = (idx < plen_reg) && (idx < 16'(CHANNELS));
            end

            if (byte_last)
            begin
                pos_next = '0;
                hv_next  = 1'b1;
            end
            else if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    assign item_idx   = idx[IW-1:0];
    assign item_level = data_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            hv_reg   <= 1'b1;
            univ_reg <= '0;
            plen_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            hv_reg   <= hv_next;
            univ_reg <= univ_next;
            plen_reg <= plen_next;
        end
    end

    a_push_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
        item_push |-> (hv_reg && pos_reg >= HDR_LEN && in_accept))
        else $error("item raised outside a valid payload");

    a_push_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        item_push |-> (idx < 16'(CHANNELS) && idx < plen_reg))
        else $error("item index out of range");

    a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !byte_last && pos_reg == POS_MAX) |=> (pos_reg == POS_MAX))
        else $error("byte position wrapped");

endmodule

// ===== design/adcd_back.sv =====
`timescale 1ns / 1ps

module adcd_back
    import adcd_pkg::*;
#(
    parameter int CHANNELS  = 512,
    parameter int IW        = 9,
    parameter int OUT_DEPTH = 4
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [IW-1:0]                  in_idx,
    input  logic [7:0]                     in_level,
    output logic                           in_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
    output logic                           out_push,
    output res_t                           out_data
);

    localparam int FW = $clog2(CHANNELS + 1);
    localparam int CW = $clog2(OUT_DEPTH + 1);

    // entries at or above the fill mark were never written and read as zero;
    // payload indices always run up from zero so the written region stays contiguous
    logic [7:0]    level_mem [CHANNELS];
    logic [7:0]    rd_data_reg;
    logic          b_valid_reg;
    logic [IW-1:0] b_idx_reg;
    logic [7:0]    b_level_reg;
    logic          b_fresh_reg;
    logic [FW-1:0] fill_reg, fill_next;
    logic          fwd_valid_reg;
    logic [IW-1:0] fwd_idx_reg;
    logic [7:0]    fwd_level_reg;
    logic [7:0]    old_level;
    logic          issue;

    // credit: the item in the compare stage always finds a slot in the result queue
    assign issue  = in_valid && ((int'(out_count) + int'(b_valid_reg)) < OUT_DEPTH);
    assign in_pop = issue;

    // the write of the previous item lands on the same edge as this item's read
    always_comb
    begin
        if (fwd_valid_reg && fwd_idx_reg == b_idx_reg)
        begin
            old_level = fwd_level_reg;
        end
        else if (b_fresh_reg)
        begin
            old_level = '0;
        end
        else
        begin
            old_level = rd_data_reg;
        end
    end

    assign out_push         = b_valid_reg && (old_level != b_level_reg);
    assign out_data.channel = 10'(b_idx_reg) + 10'd1;
    assign out_data.level   = b_level_reg;

    always_comb
    begin
        fill_next = fill_reg;
        if (b_valid_reg && FW'(b_idx_reg) == fill_reg)
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            fill_reg      <= '0;
        end
        else
        begin
            b_valid_reg   <= issue;
            fwd_valid_reg <= b_valid_reg;
            fill_reg      <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b_idx_reg   <= in_idx;
            b_level_reg <= in_level;
            b_fresh_reg <= (FW'(in_idx) >= fill_reg);
        end
        fwd_idx_reg   <= b_idx_reg;
        fwd_level_reg <= b_level_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_valid_reg)
        begin
            level_mem[b_idx_reg] <= b_level_reg;
        end
        if (issue)
        begin
            rd_data_reg <= level_mem[in_idx];
        end
    end

    a_room_for_result: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (out_count < CW'(OUT_DEPTH)))
        else $error("result queue has no room for compare stage");

    a_contiguous_fill: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (FW'(b_idx_reg) <= fill_reg))
        else $error("store write skipped past fill mark");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(CHANNELS))
        else $error("fill mark beyond channel count");

endmodule

// ===== design/artdmx_change_detector_top.sv =====
`timescale 1ns / 1ps

// ArtDmx receiver with per-channel change detection. Takes one datagram byte per
// cycle and keeps taking one per cycle while the item queue has room; a result
// (1-based channel, new level) takes this path: the edge that accepts the byte
// causing it parses the byte into the item queue, a later edge issues it with the
// level store read once the result queue has room, and the compare outcome is
// then written into the result queue. The store read-modify-write is a two-stage
// pipeline with a bypass, so back-to-back payload bytes never stall it on a hazard.
// Levels start at zero after reset with no clearing pass; a fill mark tracks which
// store entries have been written. listen_universe may be changed only while idle.
module artdmx_change_detector_top
    import adcd_pkg::*;
#(
    parameter int CHANNELS = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        byte_last,
    input  logic [15:0] datagram_length,
    output logic        empty,
    input  logic        pop,
    output logic [9:0]  channel_number,
    output logic [7:0]  channel_level,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [14:0] cfg_data
);

    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int QW = IW + 8;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [14:0]   listen_reg;
    logic          in_accept;
    logic          item_push;
    logic [IW-1:0] item_idx;
    logic [7:0]    item_level;
    logic          mid_full, mid_empty, mid_pop;
    logic [QW-1:0] mid_rdata;
    logic [CW-1:0] mid_count;
    logic          res_push;
    res_t          res_wdata;
    logic [$bits(res_t)-1:0] res_rdata;
    logic          res_full;
    logic [CW-1:0] res_count;
    res_t          res_head;

    assign cfg_ready = 1'b1;
    assign in_accept = push && !full;
    assign full      = mid_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listen_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            listen_reg <= cfg_data;
        end
    end

    adcd_front #(
        .CHANNELS (CHANNELS),
        .IW       (IW)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_accept       (in_accept),
        .data_byte       (data_byte),
        .byte_last       (byte_last),
        .datagram_length (datagram_length),
        .listen_universe (listen_reg),
        .item_push       (item_push),
        .item_idx        (item_idx),
        .item_level      (item_level)
    );

    adcd_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (item_push),
        .wdata ({item_idx, item_level}),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty),
        .count (mid_count)
    );

    adcd_back #(
        .CHANNELS  (CHANNELS),
        .IW        (IW),
        .OUT_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!mid_empty),
        .in_idx    (mid_rdata[QW-1:8]),
        .in_level  (mid_rdata[7:0]),
        .in_pop    (mid_pop),
        .out_count (res_count),
        .out_push  (res_push),
        .out_data  (res_wdata)
    );

    adcd_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty),
        .count (res_count)
    );

    assign res_head       = res_t'(res_rdata);
    assign channel_number = res_head.channel;
    assign channel_level  = res_head.level;

    a_no_result_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

    a_item_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        item_push |-> (mid_count < CW'(QUEUE_DEPTH)))
        else $error("item pushed into full queue");

    a_result_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (channel_number != '0 && channel_number <= 10'(CHANNELS)))
        else $error("result channel out of range");

endmodule

// ===== dv/adcd_level_monitor.sv =====
`timescale 1ns / 1ps

module adcd_level_monitor
    import adcd_pkg::*;
#(
    parameter int CHANNELS = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  data_byte,
    input  logic        byte_last,
    input  logic [15:0] datagram_length,
    input  logic        empty,
    input  logic        pop,
    input  logic [9:0]  channel_number,
    input  logic [7:0]  channel_level,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [14:0] cfg_data,
    output int          errors,
    output int          pending,
    output int          checked
);

    logic [15:0] pos_q;
    logic        hdr_ok;
    logic [15:0] univ_q;
    logic [15:0] plen_q;
    logic [14:0] listen_q;
    logic [7:0]  levels [CHANNELS];

    res_t due_changes [$];
    int   fail_n;
    int   checked_n;

    initial
    begin
        errors  = 0;
        pending = 0;
        checked = 0;
        fail_n    = 0;
        checked_n = 0;
    end

    // Parse one datagram byte; returns 1 with the new level when a channel changes.
    function automatic bit predict_change(input logic [7:0] b, input logic last,
                                          input logic [15:0] dlen, output res_t res);
        logic [15:0] p;
        int          idx;
        bit          hit;
        p   = pos_q;
        hit = 1'b0;
        res = '0;
        if (p < POS_ID_END)
        begin
            if (b != ART_ID[p[2:0]])
                hdr_ok = 1'b0;
        end
        else if (p == POS_OP_LO)
        begin
            if (b != OPDMX_LO)
                hdr_ok = 1'b0;
        end
        else if (p == POS_OP_HI)
        begin
            if (b != OPDMX_HI)
                hdr_ok = 1'b0;
        end
        else if (p == POS_UNIV_LO)
            univ_q = {8'h00, b};
        else if (p == POS_UNIV_HI)
            univ_q = {b, univ_q[7:0]};
        else if (p == POS_LEN_HI)
            plen_q = {b, 8'h00};
        else if (p == POS_LEN_LO)
        begin
            plen_q = {plen_q[15:8], b};
            // the length sent with this byte is the only one that counts
            if (dlen < HDR_LEN || plen_q == 16'd0 ||
                int'(dlen) < int'(HDR_LEN) + int'(plen_q) ||
                univ_q != {1'b0, listen_q})
                hdr_ok = 1'b0;
        end
        else if (p >= HDR_LEN && hdr_ok)
        begin
            idx = int'(p - HDR_LEN);
            if (idx < int'(plen_q) && idx < CHANNELS && levels[idx] != b)
            begin
                levels[idx] = b;
                res.channel = 10'(idx + 1);
                res.level   = b;
                hit = 1'b1;
            end
        end

        if (last)
        begin
            pos_q  = 16'd0;
            hdr_ok = 1'b1;
        end
        else if (pos_q != POS_MAX)
            pos_q = pos_q + 16'd1;
        return hit;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        res_t got;
        if (!rst_n)
        begin
            pos_q    = 16'd0;
            hdr_ok   = 1'b1;
            univ_q   = 16'd0;
            plen_q   = 16'd0;
            listen_q = 15'd0;
            foreach (levels[i])
                levels[i] = 8'd0;
            due_changes.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                listen_q = cfg_data;

            // a result leaving now was caused by an earlier item, so compare first
            if (pop && !empty)
            begin
                if (due_changes.size() == 0)
                begin
                    fail_n++;
                    $error("channel_number: expected none, got %0d (level %0d)",
                           channel_number, channel_level);
                end
                else
                begin
                    want = due_changes.pop_front();
                    checked_n++;
                    if (channel_number !== want.channel)
                    begin
                        fail_n++;
                        $error("channel_number: expected %0d, got %0d",
                               want.channel, channel_number);
                    end
                    if (channel_level !== want.level)
                    begin
                        fail_n++;
                        $error("channel_level: expected %0d, got %0d",
                               want.level, channel_level);
                    end
                end
            end

            if (push && !full)
            begin
                if (predict_change(data_byte, byte_last, datagram_length, got))
                    due_changes.push_back(got);
            end

            errors  <= fail_n;
            pending <= due_changes.size();
            checked <= checked_n;
        end
    end

endmodule

// ===== dv/artdmx_change_detector_top_test.sv =====
`timescale 1ns / 1ps

module artdmx_change_detector_top_test;
    import adcd_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int PHASE_BYTES   = 280;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 8;

    typedef enum int {
        DG_GOOD,
        DG_BAD_ID,
        DG_BAD_OPCODE,
        DG_OTHER_UNIVERSE,
        DG_ZERO_LENGTH,
        DG_OVERRUN,
        DG_SHORT_UDP,
        DG_TRUNCATED_HDR,
        DG_NO_END_MARK,
        DG_NOISE
    } dg_kind_e;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  data_byte = 8'd0;
    logic        byte_last = 1'b0;
    logic [15:0] datagram_length = 16'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic [9:0]  channel_number;
    logic [7:0]  channel_level;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [14:0] cfg_data = 15'd0;

    int errors;
    int pending;
    int checked;

    logic [7:0]  frame [$];
    logic [14:0] universe = 15'd0;
    bit          gaps_on = 1'b1;
    bit          hold_req = 1'b0;
    int          burst_left = 0;
    int          sent_bytes = 0;
    int          datagrams = 0;
    int          settings = 0;
    int          idle_cycles = 0;

    artdmx_change_detector_top i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .data_byte       (data_byte),
        .byte_last       (byte_last),
        .datagram_length (datagram_length),
        .empty           (empty),
        .pop             (pop),
        .channel_number  (channel_number),
        .channel_level   (channel_level),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    adcd_level_monitor i_level_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .data_byte       (data_byte),
        .byte_last       (byte_last),
        .datagram_length (datagram_length),
        .empty           (empty),
        .pop             (pop),
        .channel_number  (channel_number),
        .channel_level   (channel_level),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .errors          (errors),
        .pending         (pending),
        .checked         (checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog: cycles with no item, result or register write accepted
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[artdmx_change_detector_top] ERROR");
            $finish;
        end
    end

    // result side: stall pattern of its own, plus one long hold-off on request
    initial
    begin
        int pattern;
        int pattern_left;
        pattern = 0;
        pattern_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    pattern = $urandom_range(0, 2);
                    pattern_left = $urandom_range(20, 120);
                end
                pattern_left--;
                case (pattern)
                    0:       pop <= 1'b1;
                    1:       pop <= ($urandom_range(0, 3) != 0);
                    default: pop <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last, input logic [15:0] dlen);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = $urandom_range(1, 48);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        push            <= 1'b1;
        data_byte       <= b;
        byte_last       <= last;
        datagram_length <= dlen;
        do
            @(posedge clk);
        while (full);
        sent_bytes++;
    endtask

    // length sent with non-length bytes is random now and then; the block ignores it
    task automatic send_frame(input logic [15:0] dlen, input bit mark_end, input bit noisy);
        logic [15:0] len;
        for (int i = 0; i < frame.size(); i++)
        begin
            len = dlen;
            if (noisy && i != int'(POS_LEN_LO) && $urandom_range(0, 2) == 0)
                len = 16'($urandom);
            send_byte(frame[i], mark_end && i == frame.size() - 1, len);
        end
        datagrams++;
    endtask

    task automatic build_header(input logic [15:0] univ, input logic [15:0] plen);
        frame.delete();
        for (int i = 0; i < 8; i++)
            frame.push_back(ART_ID[i]);
        frame.push_back(OPDMX_LO);
        frame.push_back(OPDMX_HI);
        repeat (4) frame.push_back(8'($urandom));
        frame.push_back(univ[7:0]);
        frame.push_back(univ[15:8]);
        frame.push_back(plen[15:8]);
        frame.push_back(plen[7:0]);
    endtask

    task automatic add_payload(input int n);
        repeat (n)
        begin
            case ($urandom_range(0, 3))
                0:       frame.push_back(8'h00);
                1:       frame.push_back(8'hFF);
                default: frame.push_back(8'($urandom));
            endcase
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        push <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        // bytes that cause nothing may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_universe(input logic [14:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        universe = value;
        settings++;
    endtask

    task automatic random_datagram();
        dg_kind_e    kind;
        int          pick;
        int          plen;
        int          n;
        logic [15:0] univ;
        logic [15:0] dlen;
        bit          mark;
        bit          noisy;
        pick  = $urandom_range(0, 99);
        kind  = (pick < 60) ? DG_GOOD : dg_kind_e'(1 + pick % 9);
        mark  = 1'b1;
        noisy = ($urandom_range(0, 3) == 0);
        plen  = $urandom_range(1, 40);
        if (kind == DG_GOOD && $urandom_range(0, 39) == 0)
            plen = $urandom_range(500, 560);
        univ = {1'b0, universe};
        if (kind == DG_OTHER_UNIVERSE)
        begin
            if ($urandom_range(0, 1) == 1)
                univ = univ ^ 16'(1 << $urandom_range(0, 14));
            else
                univ = univ | 16'h8000;
        end

        if (kind == DG_ZERO_LENGTH)
        begin
            n = $urandom_range(0, 6);
            build_header(univ, 16'd0);
            add_payload(n);
            dlen = 16'(int'(HDR_LEN) + n);
        end
        else
        begin
            build_header(univ, 16'(plen));
            add_payload(plen);
            dlen = 16'(int'(HDR_LEN) + plen);
            if ($urandom_range(0, 1) == 1)
                dlen = dlen + 16'($urandom_range(1, 20));
            if ($urandom_range(0, 9) == 0)
                dlen = 16'hFFFF;
        end

        case (kind)
            DG_GOOD:
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                begin
                    // ends early
                    n = $urandom_range(10, frame.size() - 1);
                    while (frame.size() > n)
                        void'(frame.pop_back());
                end
                else if (pick < 30)
                    add_payload($urandom_range(1, 8));
            end
            DG_BAD_ID:
            begin
                n = $urandom_range(0, 7);
                frame[n] = frame[n] ^ 8'(1 << $urandom_range(0, 7));
            end
            DG_BAD_OPCODE:
            begin
                n = 8 + $urandom_range(0, 1);
                frame[n] = frame[n] ^ 8'(1 << $urandom_range(0, 7));
            end
            DG_OVERRUN:
                dlen = 16'(int'(HDR_LEN) + plen - $urandom_range(1, int'(HDR_LEN) + plen));
            DG_SHORT_UDP:
                dlen = 16'($urandom_range(0, int'(HDR_LEN) - 1));
            DG_TRUNCATED_HDR:
            begin
                n = $urandom_range(1, int'(HDR_LEN) - 1);
                while (frame.size() > n)
                    void'(frame.pop_back());
            end
            DG_NO_END_MARK:
                mark = 1'b0;
            DG_NOISE:
            begin
                frame.delete();
                repeat ($urandom_range(1, 30)) frame.push_back(8'($urandom));
                dlen = 16'($urandom);
            end
            default:
                ;
        endcase
        send_frame(dlen, mark, noisy);
    endtask

    initial
    begin
        logic [14:0] phase_universe [5];
        int          phase_start;
        bit          paused;
        phase_universe[0] = 15'd0;
        phase_universe[1] = 15'h7FFF;
        phase_universe[2] = 15'($urandom);
        phase_universe[3] = 15'd1;
        phase_universe[4] = 15'($urandom);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_universe(15'd0);

        // channel 1 goes to full scale, channel 2 stays at zero: one change only
        build_header(16'd0, 16'd2);
        frame.push_back(8'hFF);
        frame.push_back(8'h00);
        send_frame(16'd20, 1'b1, 1'b0);
        // a datagram cut off inside the ID
        build_header(16'd0, 16'd2);
        while (frame.size() > 5)
            void'(frame.pop_back());
        send_frame(16'd5, 1'b1, 1'b0);
        wait_drained();

        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph > 0)
            begin
                wait_drained();
                write_universe(phase_universe[ph]);
            end
            gaps_on = (ph != 1);
            phase_start = sent_bytes;
            paused = 1'b0;

            if (ph == 2)
            begin
                // long hold on the result side while a full-size universe streams in
                hold_req = 1'b1;
                // close any datagram left open so the header below is parsed
                send_byte(8'h00, 1'b1, 16'd1);
                build_header({1'b0, universe}, 16'($urandom_range(512, 540)));
                add_payload(int'({frame[16], frame[17]}));
                send_frame(16'(frame.size()), 1'b1, 1'b0);
            end

            while (sent_bytes - phase_start < PHASE_BYTES)
            begin
                if (ph == 3 && !paused && sent_bytes - phase_start > PHASE_BYTES / 2)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
                random_datagram();
            end
        end

        wait_drained();
        $display("Sent %0d bytes in %0d datagrams under %0d universe settings;",
                 sent_bytes, datagrams, settings);
        $display("%0d level changes compared, %0d mismatches.", checked, errors);
        if (errors == 0 && empty)
            $display("[artdmx_change_detector_top] OK");
        else
            $display("[artdmx_change_detector_top] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/adcd_pkg.sv
design/adcd_fifo.sv
design/adcd_front.sv
design/adcd_back.sv
design/artdmx_change_detector_top.sv
dv/adcd_level_monitor.sv
dv/artdmx_change_detector_top_test.sv
